[design/lprd_pkg.sv]
// ----------------------------------------------------------------------------
// lprd_pkg
// shared types and codes for the length-prefixed record deframer
// ----------------------------------------------------------------------------
`default_nettype none

package lprd_pkg;

    // parser phase
    typedef enum logic [2:0] {
        PH_COUNT = 3'd0,
        PH_LEN   = 3'd1,
        PH_DATA  = 3'd2,
        PH_DONE  = 3'd3,
        PH_ERROR = 3'd4
    } t_phase;

    // event codes
    localparam logic [2:0] EV_DATA     = 3'd0;
    localparam logic [2:0] EV_EMPTY    = 3'd1;
    localparam logic [2:0] EV_NOFIELDS = 3'd2;
    localparam logic [2:0] EV_END      = 3'd3;
    localparam logic [2:0] EV_ERROR    = 3'd4;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_MISMATCH = 3'd1;
    localparam logic [2:0] ERR_CORRUPT  = 3'd2;
    localparam logic [2:0] ERR_TRUNC    = 3'd3;
    localparam logic [2:0] ERR_TOO_MANY = 3'd4;

    // a field length must fit in 24 bits
    localparam logic [31:0] LEN_HIGH_MASK = 32'hFF00_0000;

    // one input item
    typedef struct packed {
        logic       kind;
        logic [7:0] stream_byte;
    } t_item;

    // one result item
    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] data_byte;
        logic [7:0] field_index;
        logic       is_header;
        logic       last_in_field;
        logic       last_in_record;
        logic [2:0] error_code;
    } t_result;

endpackage

`default_nettype wire

[design/lprd_in_reg.sv]
// ----------------------------------------------------------------------------
// lprd_in_reg
// input register stage, refills in the same cycle it is drained
// ----------------------------------------------------------------------------
`default_nettype none

module lprd_in_reg (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  lprd_pkg::t_item  i_item,
    input  wire              i_take,
    output logic             o_ready,
    output logic             o_valid,
    output lprd_pkg::t_item  o_item
);
    import lprd_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

[design/lprd_parser.sv]
// ----------------------------------------------------------------------------
// lprd_parser
// record/field state machine, one input item per fire
// ----------------------------------------------------------------------------
`default_nettype none

module lprd_parser #(
    parameter int MAX_FIELDS = 256
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_fire,
    input  lprd_pkg::t_item    i_item,
    output logic               o_emit,
    output lprd_pkg::t_result  o_result
);
    import lprd_pkg::*;

    localparam int FW = $clog2(MAX_FIELDS + 1);

    t_phase        r_phase,       n_phase;
    logic [1:0]    r_bow,         n_bow;
    logic [23:0]   r_acc,         n_acc;
    logic [FW-1:0] r_expected,    n_expected;
    logic          r_header_done, n_header_done;
    logic [FW-1:0] r_cur_field,   n_cur_field;
    logic [23:0]   r_bytes_left,  n_bytes_left;

    logic [31:0]   word;
    logic [23:0]   bytes_dec;
    logic          last_field;
    logic          do_fail;
    logic [2:0]    fail_code;
    logic          do_field_done;
    logic [2:0]    fd_event;
    logic [7:0]    fd_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_COUNT;
            r_bow         <= '0;
            r_acc         <= '0;
            r_expected    <= '0;
            r_header_done <= 1'b0;
            r_cur_field   <= '0;
            r_bytes_left  <= '0;
        end else begin
            r_phase       <= n_phase;
            r_bow         <= n_bow;
            r_acc         <= n_acc;
            r_expected    <= n_expected;
            r_header_done <= n_header_done;
            r_cur_field   <= n_cur_field;
            r_bytes_left  <= n_bytes_left;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_bow         = r_bow;
        n_acc         = r_acc;
        n_expected    = r_expected;
        n_header_done = r_header_done;
        n_cur_field   = r_cur_field;
        n_bytes_left  = r_bytes_left;
        o_emit        = 1'b0;
        o_result      = '0;
        do_fail       = 1'b0;
        fail_code     = ERR_NONE;
        do_field_done = 1'b0;
        fd_event      = EV_DATA;
        fd_byte       = 8'd0;

        word       = {r_acc, i_item.stream_byte};
        bytes_dec  = r_bytes_left - 24'd1;
        last_field = ({1'b0, r_cur_field} + {{FW{1'b0}}, 1'b1}) >= {1'b0, r_expected};

        if (i_fire) begin
            unique case (r_phase) inside
                PH_COUNT, PH_LEN: begin
                    if (i_item.kind) begin
                        if (r_phase == PH_COUNT && r_bow == 2'd0) begin
                            n_phase           = PH_DONE;
                            o_emit            = 1'b1;
                            o_result.event_res = EV_END;
                        end else begin
                            do_fail   = 1'b1;
                            fail_code = ERR_TRUNC;
                        end
                    end else begin
                        n_acc = word[23:0];
                        n_bow = r_bow + 2'd1;
                        if (r_bow == 2'd3) begin
                            n_acc = '0;
                            if (r_phase == PH_COUNT) begin
                                if (!r_header_done) begin
                                    if (word == 32'd0) begin
                                        n_phase                 = PH_DONE;
                                        o_emit                  = 1'b1;
                                        o_result.event_res      = EV_NOFIELDS;
                                        o_result.is_header      = 1'b1;
                                        o_result.last_in_field  = 1'b1;
                                        o_result.last_in_record = 1'b1;
                                    end else if (word > 32'(MAX_FIELDS)) begin
                                        do_fail   = 1'b1;
                                        fail_code = ERR_TOO_MANY;
                                    end else begin
                                        n_expected  = word[FW-1:0];
                                        n_cur_field = '0;
                                        n_phase     = PH_LEN;
                                    end
                                end else if (word != 32'(r_expected)) begin
                                    do_fail   = 1'b1;
                                    fail_code = ERR_MISMATCH;
                                end else begin
                                    n_cur_field = '0;
                                    n_phase     = PH_LEN;
                                end
                            end else begin
                                if ((word & LEN_HIGH_MASK) != 32'd0) begin
                                    do_fail   = 1'b1;
                                    fail_code = ERR_CORRUPT;
                                end else if (word == 32'd0) begin
                                    do_field_done = 1'b1;
                                    fd_event      = EV_EMPTY;
                                end else begin
                                    n_bytes_left = word[23:0];
                                    n_phase      = PH_DATA;
                                end
                            end
                        end
                    end
                end
                PH_DATA: begin
                    if (i_item.kind) begin
                        do_fail   = 1'b1;
                        fail_code = ERR_TRUNC;
                    end else begin
                        n_bytes_left = bytes_dec;
                        if (bytes_dec == 24'd0) begin
                            do_field_done = 1'b1;
                            fd_event      = EV_DATA;
                            fd_byte       = i_item.stream_byte;
                        end else begin
                            o_emit               = 1'b1;
                            o_result.event_res   = EV_DATA;
                            o_result.data_byte   = i_item.stream_byte;
                            o_result.field_index = 8'(r_cur_field);
                            o_result.is_header   = !r_header_done;
                        end
                    end
                end
                default: ;
            endcase
        end

        // sticky error
        if (do_fail) begin
            n_phase              = PH_ERROR;
            o_emit               = 1'b1;
            o_result.event_res   = EV_ERROR;
            o_result.field_index = 8'(r_cur_field);
            o_result.is_header   = !r_header_done;
            o_result.error_code  = fail_code;
        end

        // close the field, then move to next field or next record
        if (do_field_done) begin
            n_bow                   = '0;
            o_emit                  = 1'b1;
            o_result.event_res      = fd_event;
            o_result.data_byte      = fd_byte;
            o_result.field_index    = 8'(r_cur_field);
            o_result.is_header      = !r_header_done;
            o_result.last_in_field  = 1'b1;
            o_result.last_in_record = last_field;
            if (last_field) begin
                n_cur_field   = '0;
                n_header_done = 1'b1;
                n_phase       = PH_COUNT;
            end else begin
                n_cur_field = r_cur_field + {{(FW-1){1'b0}}, 1'b1};
                n_phase     = PH_LEN;
            end
        end
    end

    a_terminal_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ERROR || r_phase == PH_DONE) |=> $stable(r_phase))
        else $error("terminal phase left without reset");

    a_data_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_bytes_left != 24'd0))
        else $error("content phase with no bytes left");

    a_field_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LEN || r_phase == PH_DATA) |-> (r_cur_field < r_expected))
        else $error("field position beyond record count");

endmodule

`default_nettype wire

[design/lprd_out_reg.sv]
// ----------------------------------------------------------------------------
// lprd_out_reg
// result register, loads when empty or when the held result is taken
// ----------------------------------------------------------------------------
`default_nettype none

module lprd_out_reg (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_load,
    input  wire                i_emit,
    input  lprd_pkg::t_result  i_result,
    input  wire                i_ready,
    output logic               o_can_load,
    output logic               o_valid,
    output lprd_pkg::t_result  o_result
);
    import lprd_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_emit;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_emit) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

[design/length_prefixed_record_deframer.sv]
// ----------------------------------------------------------------------------
// length_prefixed_record_deframer
// byte-stream deframer for records of length-prefixed fields
// ----------------------------------------------------------------------------
// Takes one byte (or an end-of-input marker) per clock and accepts a new
// transaction every cycle for as long as the output side keeps up. An item
// goes through an input register, combinational parse logic and a result
// register; parsing waits while the result register is full, and the parse
// step takes one byte per fire, which sets the rate of one byte per clock.
// Records are a 4-byte big-endian field count followed, per field, by a
// 4-byte big-endian length and the content bytes. The first record is the
// header and fixes the field count of all later records. Count and length
// bytes produce no output. Content bytes and empty fields come out one per
// transaction, tagged with field position and end-of-field/record marks.
// Errors and end-of-stream are reported once, after which all input is
// swallowed until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_record_deframer #(
    parameter int MAX_FIELDS = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input stream
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] stream_byte
    input  wire         i_s_axis_tuser,   // [0] kind (1 = end of input)
    // result stream
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // [7:0] data_byte, [15:8] field_index, [16] is_header,
    // [17] last_in_field, [20:18] error_code, [23:21] zero
    output logic [23:0] o_m_axis_tdata,
    output logic [2:0]  o_m_axis_tuser,   // [2:0] event_res
    output logic        o_m_axis_tlast    // last_in_record
);
    import lprd_pkg::*;

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    can_load;
    logic    fire;
    logic    emit;
    t_result step_result;
    t_result out_result;

    assign in_item.kind        = i_s_axis_tuser;
    assign in_item.stream_byte = i_s_axis_tdata;

    // parse the held byte when the result register has room
    assign fire = held_valid && can_load;

    lprd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_item  (in_item),
        .i_take  (fire),
        .o_ready (o_s_axis_tready),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    lprd_parser #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (held_item),
        .o_emit   (emit),
        .o_result (step_result)
    );

    lprd_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_emit     (emit),
        .i_result   (step_result),
        .i_ready    (i_m_axis_tready),
        .o_can_load (can_load),
        .o_valid    (o_m_axis_tvalid),
        .o_result   (out_result)
    );

    // pack result fields, lowest first
    assign o_m_axis_tdata = {3'b000,
                             out_result.error_code,
                             out_result.last_in_field,
                             out_result.is_header,
                             out_result.field_index,
                             out_result.data_byte};
    assign o_m_axis_tuser = out_result.event_res;
    assign o_m_axis_tlast = out_result.last_in_record;

    // error code is set exactly on error events
    a_error_code_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((o_m_axis_tuser == EV_ERROR) == (o_m_axis_tdata[20:18] != ERR_NONE)))
        else $error("error code does not match event");

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for length_prefixed_record_deframer
// ----------------------------------------------------------------------------
// A short directed table opens the stream with a three-field header record
// and part of a data record. A random run of well-formed records with random
// content follows. The run ends with one stream terminator chosen at random:
// a clean end, truncation inside a count word, a length word or field
// content, a count mismatch, or a corrupt length. Random noise comes after
// it and must be swallowed. Every accepted byte goes through a software
// deframer, and every result transaction is compared field by field with
// the oldest prediction. Both sides insert random gaps. There is one long
// receiver hold-off and one sender pause that drains all results.
// ----------------------------------------------------------------------------

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lprd_pkg::*;

    localparam int N_MAX_FIELDS = 256;
    localparam int HDR_FIELDS   = 3;       // field count set by the directed header
    localparam int ITEMS_TARGET = 1650;
    localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
    localparam int LIMIT_CYCLES = 600_000;

    // terminator scenarios picked for the end of the stream
    typedef enum int {
        END_CLEAN,
        END_TRUNC_COUNT,
        END_TRUNC_LEN,
        END_TRUNC_DATA,
        END_MISMATCH,
        END_CORRUPT
    } t_ending;

    // one row of the directed table
    typedef struct {
        logic       kind;
        logic [7:0] b;
        bit         typed;     // expected result typed in below
        t_result    want;
    } t_row;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_kind  = 1'b0;
    logic [7:0]  s_byte  = 8'h00;
    logic        m_ready = 1'b0;
    wire         s_ready;
    wire         m_valid;
    wire  [23:0] m_data;
    wire  [2:0]  m_user;
    wire         m_last;

    length_prefixed_record_deframer #(
        .MAX_FIELDS (N_MAX_FIELDS)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_byte),   // [7:0] stream_byte
        .i_s_axis_tuser  (s_kind),   // [0] kind
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        // [7:0] data_byte, [15:8] field_index, [16] is_header,
        // [17] last_in_field, [20:18] error_code, [23:21] zero
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),   // [2:0] event_res
        .o_m_axis_tlast  (m_last)    // last_in_record
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // software deframer: own copy of the parse state
    // ------------------------------------------------------------------------
    t_phase      df_phase     = PH_COUNT;
    logic [1:0]  df_nbyte     = '0;
    logic [31:0] df_word      = '0;
    logic [8:0]  df_nfields   = '0;
    logic        df_hdr_done  = 1'b0;
    logic [8:0]  df_field     = '0;
    logic [23:0] df_left      = '0;

    t_result     deframe_q[$];   // predicted result transactions, oldest first
    int          n_fail  = 0;
    int          n_items = 0;    // accepted input transactions
    bit          calm    = 1'b0; // no gaps on either side while set
    bit          hold_go = 1'b0; // asks the receiver for its long hold-off
    bit          hold_taken = 1'b0;
    int          rx_hold  = 0;
    int          rx_stall = 0;

    function automatic t_result make_res(logic [2:0] ev, logic [7:0] db, logic [7:0] idx,
                                         logic hdr, logic lf, logic lr, logic [2:0] err);
        t_result r;
        r.event_res      = ev;
        r.data_byte      = db;
        r.field_index    = idx;
        r.is_header      = hdr;
        r.last_in_field  = lf;
        r.last_in_record = lr;
        r.error_code     = err;
        return r;
    endfunction

    // errors stick: the phase goes to error and the rest is swallowed
    function automatic t_result raise_err(logic [2:0] code);
        df_phase = PH_ERROR;
        return make_res(EV_ERROR, 8'h00, df_field[7:0], !df_hdr_done, 1'b0, 1'b0, code);
    endfunction

    // closing event of a field, then on to the next field or record
    function automatic t_result close_field(logic [2:0] ev, logic [7:0] db);
        logic [7:0] idx;
        logic       hdr;
        logic       last;
        idx  = df_field[7:0];
        hdr  = !df_hdr_done;
        last = (32'(df_field) + 1 >= 32'(df_nfields));
        df_nbyte = '0;
        if (last) begin
            df_field    = '0;
            df_hdr_done = 1'b1;
            df_phase    = PH_COUNT;
        end else begin
            df_field = df_field + 1'b1;
            df_phase = PH_LEN;
        end
        return make_res(ev, db, idx, hdr, 1'b1, last, ERR_NONE);
    endfunction

    // one accepted input; returns 1 when it causes a result
    function automatic bit deframe_step(input logic kind, input logic [7:0] b,
                                        output t_result r);
        logic [31:0] w;
        r = '0;
        if (!(df_phase == PH_COUNT || df_phase == PH_LEN || df_phase == PH_DATA))
            return 1'b0;
        if (kind) begin
            // end of input is clean only on a record boundary
            if (df_phase == PH_COUNT && df_nbyte == 2'd0) begin
                df_phase = PH_DONE;
                r = make_res(EV_END, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, ERR_NONE);
            end else begin
                r = raise_err(ERR_TRUNC);
            end
            return 1'b1;
        end
        if (df_phase == PH_DATA) begin
            df_left = df_left - 1'b1;
            if (df_left == '0)
                r = close_field(EV_DATA, b);
            else
                r = make_res(EV_DATA, b, df_field[7:0], !df_hdr_done, 1'b0, 1'b0, ERR_NONE);
            return 1'b1;
        end
        // count and length words arrive big-endian
        w = {df_word[23:0], b};
        if (df_nbyte != 2'd3) begin
            df_word  = w;
            df_nbyte = df_nbyte + 1'b1;
            return 1'b0;
        end
        df_nbyte = '0;
        df_word  = '0;
        if (df_phase == PH_COUNT) begin
            if (!df_hdr_done) begin
                if (w == '0) begin
                    df_phase = PH_DONE;
                    r = make_res(EV_NOFIELDS, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, ERR_NONE);
                    return 1'b1;
                end
                if (w > N_MAX_FIELDS) begin
                    r = raise_err(ERR_TOO_MANY);
                    return 1'b1;
                end
                df_nfields = w[8:0];
            end else if (w != 32'(df_nfields)) begin
                r = raise_err(ERR_MISMATCH);
                return 1'b1;
            end
            df_field = '0;
            df_phase = PH_LEN;
            return 1'b0;
        end
        if ((w & LEN_HIGH_MASK) != '0) begin
            r = raise_err(ERR_CORRUPT);
            return 1'b1;
        end
        if (w == '0) begin
            r = close_field(EV_EMPTY, 8'h00);
            return 1'b1;
        end
        df_left  = w[23:0];
        df_phase = PH_DATA;
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // gap and length shaping
    // ------------------------------------------------------------------------
    // mostly back-to-back, sometimes short gaps, rarely a long one
    function automatic int pick_gap(int longest);
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(11, longest);
    endfunction

    // mostly short fields, a few empty, about one in a hundred past 255 bytes
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 199);
        if (r < 20)  return 0;
        if (r < 170) return $urandom_range(1, 6);
        if (r < 198) return $urandom_range(7, 40);
        return $urandom_range(256, 300);
    endfunction

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------
    // offer one transaction and wait for it to be taken; valid stays high
    // afterwards so a following back-to-back item needs no second assignment
    task automatic offer(input logic kind, input logic [7:0] b, input bit typed,
                         input t_result want);
        int      gap;
        bit      has;
        t_result got;
        gap = (calm || rx_hold > 0) ? 0 : pick_gap(60);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_byte  <= b;
        do @(posedge clk); while (!s_ready);
        has = deframe_step(kind, b, got);
        if (typed)
            deframe_q.push_back(want);
        else if (has)
            deframe_q.push_back(got);
        n_items++;
        // switch between calm stretches and gappy stretches now and then
        if (n_items % 150 == 0)
            calm = ($urandom_range(0, 2) == 0);
    endtask

    task automatic send_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            offer(1'b0, w[i*8 +: 8], 1'b0, '0);
    endtask

    task automatic send_field();
        int len;
        len = pick_len();
        send_word(32'(len));
        repeat (len) offer(1'b0, 8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------------
    // receiver side: random stalls plus one long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            rx_hold    = HOLD_CYCLES - 1;
            m_ready   <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!calm)
                rx_stall = pick_gap(40);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    // compare each result transaction with the oldest prediction
    always @(posedge clk) begin
        t_result got;
        t_result want;
        if (rst_n && m_valid && m_ready) begin
            got = make_res(m_user, m_data[7:0], m_data[15:8], m_data[16], m_data[17],
                           m_last, m_data[20:18]);
            if (deframe_q.size() == 0) begin
                $error("result transaction with nothing expected, event_res %0d",
                       got.event_res);
                n_fail++;
            end else begin
                want = deframe_q.pop_front();
                check_field("event_res", want.event_res, got.event_res);
                check_field("data_byte", want.data_byte, got.data_byte);
                check_field("field_index", want.field_index, got.field_index);
                check_field("is_header", want.is_header, got.is_header);
                check_field("last_in_field", want.last_in_field, got.last_in_field);
                check_field("last_in_record", want.last_in_record, got.last_in_record);
                check_field("error_code", want.error_code, got.error_code);
            end
        end
    end

    // run limit
    initial begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        t_row        opening [27];
        int          rec;
        int          k;
        t_ending     ending;
        logic [31:0] w;

        // header of three fields, then the start of the first data record
        opening = '{
            '{1'b0, 8'h00, 1'b0, '0},   // header field count
            '{1'b0, 8'h00, 1'b0, '0},
            '{1'b0, 8'h00, 1'b0, '0},
            '{1'b0, 8'h03, 1'b0, '0},
            '{1'b0, 8'h00, 1'b0, '0},   // field 0, length 1
            '{1'b0, 8'h00, 1'b0, '0},
            '{1'b0, 8'h00, 1'b0, '0},
            '{1'b0, 8'h01, 1'b0, '0},
            '{1'b0, 8'hFF, 1'b1,
              make_res(EV_DATA, 8'hFF, 8'd0, 1'b1, 1'b1, 1'b0, ERR_NONE)},
            '{1'b0, 8'h00, 1'b0, '0},   // field 1, empty
            '{1'b0, 8'h00, 1'b0, '0},
            '{1'b0, 8'h00, 1'b0, '0},
            '{1'b0, 8'h00, 1'b1,
              make_res(EV_EMPTY, 8'h00, 8'd1, 1'b1, 1'b1, 1'b0, ERR_NONE)},
            '{1'b0, 8'h00, 1'b0, '0},   // field 2, length 2, closes the header
            '{1'b0, 8'h00, 1'b0, '0},
            '{1'b0, 8'h00, 1'b0, '0},
            '{1'b0, 8'h02, 1'b0, '0},
            '{1'b0, 8'h00, 1'b1,
              make_res(EV_DATA, 8'h00, 8'd2, 1'b1, 1'b0, 1'b0, ERR_NONE)},
            '{1'b0, 8'h80, 1'b1,
              make_res(EV_DATA, 8'h80, 8'd2, 1'b1, 1'b1, 1'b1, ERR_NONE)},
            '{1'b0, 8'h00, 1'b0, '0},   // first data record, matching count
            '{1'b0, 8'h00, 1'b0, '0},
            '{1'b0, 8'h00, 1'b0, '0},
            '{1'b0, 8'h03, 1'b0, '0},
            '{1'b0, 8'h00, 1'b0, '0},   // its field 0, empty
            '{1'b0, 8'h00, 1'b0, '0},
            '{1'b0, 8'h00, 1'b0, '0},
            '{1'b0, 8'h00, 1'b1,
              make_res(EV_EMPTY, 8'h00, 8'd0, 1'b0, 1'b1, 1'b0, ERR_NONE)}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (opening[i])
            offer(opening[i].kind, opening[i].b, opening[i].typed, opening[i].want);

        // finish the open record, then whole records with random content
        for (int f = 1; f < HDR_FIELDS; f++)
            send_field();
        rec = 0;
        while (n_items < ITEMS_TARGET) begin
            if (rec == 8) begin
                // sender pause until every result has drained
                s_valid <= 1'b0;
                @(posedge clk);
                while (deframe_q.size() != 0) @(posedge clk);
            end
            if (rec == 20)
                hold_go = 1'b1;   // receiver holds off while bytes keep coming
            send_word(32'(HDR_FIELDS));
            repeat (HDR_FIELDS) send_field();
            rec++;
        end

        // end the stream one way or another
        ending = t_ending'($urandom_range(0, 5));
        case (ending)
            END_CLEAN: begin
                offer(1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);
            end
            END_TRUNC_COUNT: begin
                repeat ($urandom_range(1, 3)) offer(1'b0, 8'h00, 1'b0, '0);
                offer(1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);
            end
            END_TRUNC_LEN: begin
                send_word(32'(HDR_FIELDS));
                repeat ($urandom_range(0, HDR_FIELDS - 1)) send_field();
                repeat ($urandom_range(0, 3)) offer(1'b0, 8'h00, 1'b0, '0);
                offer(1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);
            end
            END_TRUNC_DATA: begin
                send_word(32'(HDR_FIELDS));
                send_word(32'd5);
                repeat ($urandom_range(0, 4)) offer(1'b0, 8'($urandom_range(0, 255)),
                                                   1'b0, '0);
                offer(1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);
            end
            END_MISMATCH: begin
                // small counts and zero as often as wild ones
                w = $urandom_range(0, 1) ? 32'($urandom_range(0, 8)) : $urandom;
                if (w == 32'(HDR_FIELDS))
                    w = '0;
                send_word(w);
            end
            default: begin
                send_word(32'(HDR_FIELDS));
                k = $urandom_range(0, HDR_FIELDS - 1);
                repeat (k) send_field();
                send_word({8'($urandom_range(1, 255)), 24'($urandom)});
            end
        endcase

        // everything after the end must be swallowed
        repeat ($urandom_range(8, 20))
            offer(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, '0);
        s_valid <= 1'b0;

        while (deframe_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (n_fail == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
